### rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AST_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define AST_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// state in the cycle after reset is applied
`define AST_AFTER_RST(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("post-reset check failed");

`endif

### rtl/lj_pkg.sv
// types and constants of the lennard-jones pair force pipeline
package lj_pkg;

  // axes in use (2 or 3) and axes carried on the ports
  localparam int DIMS  = 3;
  localparam int NAXES = 3;

  // field and datapath widths
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int POS_W      = 32;
  localparam int DISP_W     = POS_W + 1;
  localparam int BOX_W      = 31;
  localparam int MAG_W      = 24;
  localparam int R2_W       = 2 * MAG_W + 2;
  localparam int FRAC_W     = 16;
  localparam int Q_W        = 63;
  localparam int MUL_W      = 64;
  localparam int MUL_SH_W   = 6;
  localparam int OUT_W      = 48;
  localparam int EV_W       = 53;

  // pipeline depths
  localparam int MOD_STEPS  = DISP_W;
  localparam int FRONT_LAT  = MOD_STEPS + 8;
  localparam int DIV_SH     = 32;
  localparam int DIV_STEPS  = Q_W + DIV_SH;
  localparam int MUL_LAT    = 4;

  // stream widths
  localparam int IN_W       = 2 * NAXES * POS_W;
  localparam int DATA_W     = (NAXES + 1) * OUT_W;
  localparam int USER_W     = 2;

  // fixed-point limits
  localparam logic [Q_W-1:0]   ICAP    = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [Q_W-1:0]   OCAP    = Q_W'(64'h0004_0000_0000_0000);
  localparam logic [Q_W-1:0]   ONE_Q32 = Q_W'(64'h0000_0001_0000_0000);
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // product scaling shifts
  localparam logic [MUL_SH_W-1:0] SH_Q32    = MUL_SH_W'(32);
  localparam logic [MUL_SH_W-1:0] SH_ENERGY = MUL_SH_W'(30);
  localparam logic [MUL_SH_W-1:0] SH_FORCE  = MUL_SH_W'(16);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WELL_DEPTH   = 3'd0,
    REG_SIGMA_SIXTH  = 3'd1,
    REG_CUTOFF_SQ    = 3'd2,
    REG_ENERGY_SHIFT = 3'd3,
    REG_BOX_X        = 3'd4,
    REG_BOX_Y        = 3'd5,
    REG_BOX_Z        = 3'd6,
    REG_PERIODIC     = 3'd7
  } reg_index_t;

  // clip level of a scaled product
  typedef enum logic {
    CAP_INNER = 1'b0,
    CAP_OUTER = 1'b1
  } cap_t;

  // per-pair data that rides beside the arithmetic
  typedef struct packed {
    logic [R2_W-1:0]             r2;
    logic [NAXES-1:0][MAG_W-1:0] mag;
    logic [NAXES-1:0]            dneg;
    logic                        hit;
    logic                        sat;
    logic                        eneg;
    logic                        fneg;
    logic [OUT_W-1:0]            energy;
  } side_t;

endpackage

### rtl/lj_front.sv
// displacement, periodic wrap, squared distance and cutoff test
module lj_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [lj_pkg::NAXES-1:0][lj_pkg::POS_W-1:0] first_pos,
  input  logic [lj_pkg::NAXES-1:0][lj_pkg::POS_W-1:0] second_pos,
  input  logic                                    periodic_mode,
  input  logic [lj_pkg::NAXES-1:0][lj_pkg::BOX_W-1:0] box_len,
  input  logic [lj_pkg::CFG_W-1:0]                cutoff_squared,
  output logic                                    out_valid,
  output lj_pkg::side_t                           side_out
);

  localparam int LAT = lj_pkg::FRONT_LAT;
  localparam int DW  = lj_pkg::DISP_W;
  localparam int BW  = lj_pkg::BOX_W;
  localparam int MW  = lj_pkg::MAG_W;
  localparam int NS  = lj_pkg::MOD_STEPS;

  logic [LAT-1:0] vld;

  // per-axis results of the square stage
  logic [2*MW-1:0] sq_d   [lj_pkg::NAXES];
  logic            far_d  [lj_pkg::NAXES];
  logic [MW-1:0]   mag_d  [lj_pkg::NAXES];
  logic            dneg_d [lj_pkg::NAXES];

  // sum stage
  logic [lj_pkg::R2_W-1:0]                 r2_e;
  logic                                    far_e;
  logic [lj_pkg::NAXES-1:0][MW-1:0]        mag_e;
  logic [lj_pkg::NAXES-1:0]                dneg_e;
  logic [lj_pkg::R2_W-1:0]                 r2_sum;
  logic                                    far_any;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

  for (genvar m = 0; m < lj_pkg::NAXES; m++) begin : g_axis
    logic signed [DW-1:0] x0;
    logic [DW-1:0]        ax1;
    logic signed [DW-1:0] x1;
    logic                 wr1;
    logic [BW-1:0]        mrem [NS];
    logic [DW-1:0]        mn   [NS];
    logic signed [DW-1:0] mx   [NS];
    logic                 mw   [NS];
    logic [BW-1:0]        ra;
    logic signed [DW-1:0] xa;
    logic                 wa;
    logic signed [DW-1:0] db;
    logic [DW-1:0]        ab;
    logic [MW-1:0]        magc;
    logic                 farc;
    logic                 dnegc;
    logic [2*MW-1:0]      sq;
    logic                 fard;
    logic [MW-1:0]        magd;
    logic                 dnegd;

    // difference of positions, unused axes forced to zero
    always_ff @(posedge clk) begin
      if (en) begin
        if (m < lj_pkg::DIMS) begin
          x0 <= DW'($signed(first_pos[m])) - DW'($signed(second_pos[m]));
        end else begin
          x0 <= '0;
        end
      end
    end

    // magnitude and wrap select
    always_ff @(posedge clk) begin
      if (en) begin
        ax1 <= x0[DW-1] ? DW'(-x0) : DW'(x0);
        x1  <= x0;
        wr1 <= periodic_mode && (box_len[m] != '0);
      end
    end

    // restoring remainder of the magnitude by the box length, one bit a stage
    for (genvar j = 0; j < NS; j++) begin : g_mod
      logic [BW-1:0]        rem_p;
      logic [DW-1:0]        n_p;
      logic signed [DW-1:0] x_p;
      logic                 w_p;
      logic [BW:0]          remsh;
      logic                 ge;

      if (j == 0) begin : g_first
        assign rem_p = '0;
        assign n_p   = ax1;
        assign x_p   = x1;
        assign w_p   = wr1;
      end else begin : g_rest
        assign rem_p = mrem[j-1];
        assign n_p   = mn[j-1];
        assign x_p   = mx[j-1];
        assign w_p   = mw[j-1];
      end

      assign remsh = {rem_p, n_p[DW-1]};
      assign ge    = remsh >= {1'b0, box_len[m]};

      always_ff @(posedge clk) begin
        if (en) begin
          mrem[j] <= ge ? BW'(remsh - {1'b0, box_len[m]}) : remsh[BW-1:0];
          mn[j]   <= {n_p[DW-2:0], 1'b0};
          mx[j]   <= x_p;
          mw[j]   <= w_p;
        end
      end
    end

    // floored remainder
    always_ff @(posedge clk) begin
      if (en) begin
        if (mx[NS-1] < 0 && mrem[NS-1] != '0) begin
          ra <= box_len[m] - mrem[NS-1];
        end else begin
          ra <= mrem[NS-1];
        end
        xa <= mx[NS-1];
        wa <= mw[NS-1];
      end
    end

    // fold into the half-open range around zero
    always_ff @(posedge clk) begin
      if (en) begin
        if (!wa) begin
          db <= xa;
        end else if ({ra, 1'b0} > {1'b0, box_len[m]}) begin
          db <= $signed({2'b00, ra} - {2'b00, box_len[m]});
        end else begin
          db <= $signed({2'b00, ra});
        end
      end
    end

    assign ab = db[DW-1] ? DW'(-db) : DW'(db);

    // magnitude, sign and far-axis test
    always_ff @(posedge clk) begin
      if (en) begin
        magc  <= ab[MW-1:0];
        farc  <= |ab[DW-1:MW];
        dnegc <= db[DW-1];
      end
    end

    // square of the displacement
    always_ff @(posedge clk) begin
      if (en) begin
        sq    <= farc ? '0 : magc * magc;
        fard  <= farc;
        magd  <= magc;
        dnegd <= dnegc;
      end
    end

    assign sq_d[m]   = sq;
    assign far_d[m]  = fard;
    assign mag_d[m]  = magd;
    assign dneg_d[m] = dnegd;
  end

  // squared distance over the axes
  always_comb begin
    r2_sum  = '0;
    far_any = 1'b0;
    for (int k = 0; k < lj_pkg::NAXES; k++) begin
      r2_sum  = r2_sum + lj_pkg::R2_W'(sq_d[k]);
      far_any = far_any | far_d[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_e  <= r2_sum;
      far_e <= far_any;
      for (int k = 0; k < lj_pkg::NAXES; k++) begin
        mag_e[k]  <= mag_d[k];
        dneg_e[k] <= dneg_d[k];
      end
    end
  end

  // cutoff and self-pair test
  always_ff @(posedge clk) begin
    if (en) begin
      side_out.r2     <= r2_e;
      side_out.mag    <= mag_e;
      side_out.dneg   <= dneg_e;
      side_out.hit    <= !far_e && (r2_e != '0) &&
                         (r2_e < lj_pkg::R2_W'({cutoff_squared, {lj_pkg::FRAC_W{1'b0}}}));
      side_out.sat    <= 1'b0;
      side_out.eneg   <= 1'b0;
      side_out.fneg   <= 1'b0;
      side_out.energy <= '0;
    end
  end

endmodule

### rtl/lj_div.sv
// pipelined restoring divider: floor(num * 2^32 / r2), clipped to 2^62
module lj_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [lj_pkg::Q_W-1:0]    num,
  input  logic [lj_pkg::R2_W-1:0]   den,
  input  lj_pkg::side_t             side_in,
  output logic                      out_valid,
  output logic [lj_pkg::Q_W-1:0]    quot,
  output lj_pkg::side_t             side_out
);

  localparam int NS = lj_pkg::DIV_STEPS;
  localparam int QW = lj_pkg::Q_W;
  localparam int RW = lj_pkg::R2_W;

  logic          v   [NS];
  logic [RW-1:0] rem [NS];
  logic [QW-1:0] q   [NS];
  logic          stk [NS];
  logic [QW-1:0] nsh [NS];
  logic [RW-1:0] dn  [NS];
  lj_pkg::side_t sd  [NS];
  logic          big;

  // one quotient bit per stage, dividend bits shifted in from the top
  for (genvar j = 0; j < NS; j++) begin : g_step
    logic          v_p;
    logic [RW-1:0] rem_p;
    logic [QW-1:0] q_p;
    logic          stk_p;
    logic [QW-1:0] n_p;
    logic [RW-1:0] den_p;
    lj_pkg::side_t side_p;
    logic [RW:0]   remsh;
    logic          ge;

    if (j == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign q_p    = '0;
      assign stk_p  = 1'b0;
      assign n_p    = num;
      assign den_p  = den;
      assign side_p = side_in;
    end else begin : g_rest
      assign v_p    = v[j-1];
      assign rem_p  = rem[j-1];
      assign q_p    = q[j-1];
      assign stk_p  = stk[j-1];
      assign n_p    = nsh[j-1];
      assign den_p  = dn[j-1];
      assign side_p = sd[j-1];
    end

    assign remsh = {rem_p, n_p[QW-1]};
    assign ge    = remsh >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? RW'(remsh - {1'b0, den_p}) : remsh[RW-1:0];
        q[j]   <= {q_p[QW-2:0], ge};
        stk[j] <= stk_p | q_p[QW-1];
        nsh[j] <= {n_p[QW-2:0], 1'b0};
        dn[j]  <= den_p;
        sd[j]  <= side_p;
      end
    end
  end

  // clip anything above 2^62
  assign big       = stk[NS-1] | (q[NS-1][QW-1] & (|q[NS-1][QW-2:0]));
  assign quot      = big ? lj_pkg::ICAP : q[NS-1];
  assign out_valid = v[NS-1];

  always_comb begin
    side_out     = sd[NS-1];
    side_out.sat = sd[NS-1].sat | big;
  end

endmodule

### rtl/lj_mul.sv
// 64x64 product from 32x32 partials, scaled down and clipped
module lj_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [lj_pkg::MUL_W-1:0]     a,
  input  logic [lj_pkg::MUL_W-1:0]     b,
  input  logic [lj_pkg::MUL_SH_W-1:0]  shift,
  input  lj_pkg::cap_t                 cap,
  input  lj_pkg::side_t                side_in,
  output logic                         out_valid,
  output logic [lj_pkg::Q_W-1:0]       result,
  output lj_pkg::side_t                side_out
);

  localparam int W  = lj_pkg::MUL_W;
  localparam int H  = W / 2;
  localparam int QW = lj_pkg::Q_W;

  logic [lj_pkg::MUL_LAT-1:0] v;
  logic [2*H-1:0]  pp_ll, pp_lh, pp_hl, pp_hh;
  logic [2*H-1:0]  ll2, hh2;
  logic [2*H:0]    mid2;
  logic [2*W-1:0]  prod3;
  logic [2*W-1:0]  scaled;
  logic [QW-1:0]   capv;
  logic            over;
  lj_pkg::side_t   sd1, sd2, sd3;
  lj_pkg::side_t   sd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[lj_pkg::MUL_LAT-2:0], in_valid};
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a[H-1:0] * b[H-1:0];
      pp_lh <= a[H-1:0] * b[W-1:H];
      pp_hl <= a[W-1:H] * b[H-1:0];
      pp_hh <= a[W-1:H] * b[W-1:H];
      sd1   <= side_in;
    end
  end

  // middle terms
  always_ff @(posedge clk) begin
    if (en) begin
      mid2 <= {1'b0, pp_lh} + {1'b0, pp_hl};
      ll2  <= pp_ll;
      hh2  <= pp_hh;
      sd2  <= sd1;
    end
  end

  // full product
  always_ff @(posedge clk) begin
    if (en) begin
      prod3 <= {hh2, ll2} + ((2*W)'(mid2) << H);
      sd3   <= sd2;
    end
  end

  // scale and clip
  assign scaled = prod3 >> shift;
  assign capv   = (cap == lj_pkg::CAP_INNER) ? lj_pkg::ICAP : lj_pkg::OCAP;
  assign over   = scaled > (2*W)'(capv);

  always_comb begin
    sd4     = sd3;
    sd4.sat = sd3.sat | over;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result   <= over ? capv : scaled[QW-1:0];
      side_out <= sd4;
    end
  end

  assign out_valid = v[lj_pkg::MUL_LAT-1];

endmodule

### rtl/lennard_jones_pair_force.sv
// Lennard-Jones 12-6 pair force with cutoff: takes one atom pair per transfer and returns the
// force on the first atom and the shifted pair energy (Q32.16, saturated), with zeros for pairs
// outside the cutoff or at zero distance. A new pair can be taken every clock cycle while tready
// is high; the pipeline depth is set mostly by the four 95-stage bit-per-stage dividers (three
// for sigma^6/r^6, one for the force over r^2) behind the 41-stage wrap and distance front end.
// One result can wait at the output while the pipeline keeps moving; input tready drops only
// when a second finished result is parked behind it.
module lennard_jones_pair_force (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [lj_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // force_x, force_y, force_z, pair_energy
  output logic [lj_pkg::DATA_W-1:0]     m_axis_tdata,
  // in_range, saturated
  output logic [lj_pkg::USER_W-1:0]     m_axis_tuser,
  input  logic                          cfg_we,
  input  logic [lj_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lj_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int NA = lj_pkg::NAXES;
  localparam int QW = lj_pkg::Q_W;
  localparam int MW = lj_pkg::MUL_W;
  localparam int OW = lj_pkg::OUT_W;
  localparam int EW = lj_pkg::EV_W;

  // configuration registers
  logic [lj_pkg::CFG_W-1:0]                well_depth;
  logic [lj_pkg::CFG_W-1:0]                sigma_sixth;
  logic [lj_pkg::CFG_W-1:0]                cutoff_squared;
  logic [lj_pkg::CFG_W-1:0]                energy_shift;
  logic [NA-1:0][lj_pkg::BOX_W-1:0]        box_len;
  logic                                    periodic_mode;
  logic [lj_pkg::CFG_W+4:0]                eps24;

  logic                                    en;
  logic [NA-1:0][lj_pkg::POS_W-1:0]        first_pos, second_pos;

  logic                                    v_fr, v_d1, v_d2, v_d3, v_t;
  lj_pkg::side_t                           s_fr, s_d1, s_d2, s_d3, s_t;
  lj_pkg::side_t                           s_t_next;
  logic [QW-1:0]                           q1, q2, q3;

  logic [MW-1:0]                           b2_t, te_t, tf_t;
  logic [MW-1:0]                           two_b2;

  logic                                    v_p, v_g, v_e, v_h, v_en, v_w;
  lj_pkg::side_t                           s_p, s_g, s_pg, s_e, s_h, s_en, s_w;
  lj_pkg::side_t                           s_en_next;
  logic [QW-1:0]                           p_mag, g_mag, e_mag, h_mag, h_en, w_mag;

  logic signed [EW-1:0]                    e_s, sh_s, ev;
  logic [EW-OW:0]                          ev_top;

  logic [NA-1:0]                           v_f;
  lj_pkg::side_t                           s_f [NA];
  logic [NA-1:0][QW-1:0]                   f_mag;
  logic                                    v_last;
  logic                                    sat_f;

  logic [lj_pkg::DATA_W-1:0]               fin_data;
  logic [lj_pkg::USER_W-1:0]               fin_user;
  logic                                    incoming;
  logic                                    skid_valid;
  logic [lj_pkg::DATA_W-1:0]               skid_data;
  logic [lj_pkg::USER_W-1:0]               skid_user;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      well_depth     <= 32'd65536;
      sigma_sixth    <= 32'd65536;
      cutoff_squared <= 32'd589824;
      energy_shift   <= '0;
      box_len        <= {NA{31'd655360}};
      periodic_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (lj_pkg::reg_index_t'(cfg_index))
        lj_pkg::REG_WELL_DEPTH:   well_depth     <= cfg_wdata;
        lj_pkg::REG_SIGMA_SIXTH:  sigma_sixth    <= cfg_wdata;
        lj_pkg::REG_CUTOFF_SQ:    cutoff_squared <= cfg_wdata;
        lj_pkg::REG_ENERGY_SHIFT: energy_shift   <= cfg_wdata;
        lj_pkg::REG_BOX_X:        box_len[0]     <= cfg_wdata[lj_pkg::BOX_W-1:0];
        lj_pkg::REG_BOX_Y:        box_len[1]     <= cfg_wdata[lj_pkg::BOX_W-1:0];
        lj_pkg::REG_BOX_Z:        box_len[2]     <= cfg_wdata[lj_pkg::BOX_W-1:0];
        lj_pkg::REG_PERIODIC:     periodic_mode  <= cfg_wdata[0];
      endcase
    end
  end

  // 24 * epsilon for the force prefactor
  always_ff @(posedge clk) begin
    eps24 <= {well_depth, 4'b0000} + {1'b0, well_depth, 3'b000};
  end

  // whole pipeline moves unless a result is parked in the skid stage
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  for (genvar m = 0; m < NA; m++) begin : g_unpack
    assign first_pos[m]  = s_axis_tdata[m*lj_pkg::POS_W +: lj_pkg::POS_W];
    assign second_pos[m] = s_axis_tdata[(m+NA)*lj_pkg::POS_W +: lj_pkg::POS_W];
  end

  // wrap, squared distance, cutoff
  lj_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (s_axis_tvalid),
    .first_pos      (first_pos),
    .second_pos     (second_pos),
    .periodic_mode  (periodic_mode),
    .box_len        (box_len),
    .cutoff_squared (cutoff_squared),
    .out_valid      (v_fr),
    .side_out       (s_fr)
  );

  // b2 = sigma^6 / r2 / r2 / r2
  lj_div u_div1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_fr),
    .num(QW'({sigma_sixth, {lj_pkg::FRAC_W{1'b0}}})), .den(s_fr.r2), .side_in(s_fr),
    .out_valid(v_d1), .quot(q1), .side_out(s_d1)
  );

  lj_div u_div2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_d1),
    .num(q1), .den(s_d1.r2), .side_in(s_d1),
    .out_valid(v_d2), .quot(q2), .side_out(s_d2)
  );

  lj_div u_div3 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_d2),
    .num(q2), .den(s_d2.r2), .side_in(s_d2),
    .out_valid(v_d3), .quot(q3), .side_out(s_d3)
  );

  // distances of b2 and 2*b2 from one
  assign two_b2 = {q3, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t <= 1'b0;
    end else if (en) begin
      v_t <= v_d3;
    end
  end

  always_comb begin
    s_t_next      = s_d3;
    s_t_next.eneg = q3 < lj_pkg::ONE_Q32;
    s_t_next.fneg = two_b2 < MW'(lj_pkg::ONE_Q32);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_t <= MW'(q3);
      te_t <= (q3 < lj_pkg::ONE_Q32) ? MW'(lj_pkg::ONE_Q32 - q3) :
                                       MW'(q3 - lj_pkg::ONE_Q32);
      tf_t <= (two_b2 < MW'(lj_pkg::ONE_Q32)) ? MW'(lj_pkg::ONE_Q32) - two_b2 :
                                                two_b2 - MW'(lj_pkg::ONE_Q32);
      s_t  <= s_t_next;
    end
  end

  // p = b2*|b2-1|, g = b2*|2*b2-1|
  lj_mul u_mul_p (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_t),
    .a(b2_t), .b(te_t), .shift(lj_pkg::SH_Q32), .cap(lj_pkg::CAP_INNER), .side_in(s_t),
    .out_valid(v_p), .result(p_mag), .side_out(s_p)
  );

  lj_mul u_mul_g (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_t),
    .a(b2_t), .b(tf_t), .shift(lj_pkg::SH_Q32), .cap(lj_pkg::CAP_INNER), .side_in(s_t),
    .out_valid(v_g), .result(g_mag), .side_out(s_g)
  );

  always_comb begin
    s_pg     = s_p;
    s_pg.sat = s_p.sat | s_g.sat;
  end

  // e = 4*eps*p, h = 24*eps*g
  lj_mul u_mul_e (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_p & v_g),
    .a(MW'(well_depth)), .b(MW'(p_mag)), .shift(lj_pkg::SH_ENERGY),
    .cap(lj_pkg::CAP_OUTER), .side_in(s_pg),
    .out_valid(v_e), .result(e_mag), .side_out(s_e)
  );

  lj_mul u_mul_h (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_p & v_g),
    .a(MW'(eps24)), .b(MW'(g_mag)), .shift(lj_pkg::SH_FORCE),
    .cap(lj_pkg::CAP_INNER), .side_in(s_pg),
    .out_valid(v_h), .result(h_mag), .side_out(s_h)
  );

  // signed energy minus shift, saturated to 48 bits
  assign e_s    = EW'(e_mag);
  assign sh_s   = EW'($signed(energy_shift));
  assign ev     = (s_e.eneg ? -e_s : e_s) - sh_s;
  assign ev_top = ev[EW-1:OW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_en <= 1'b0;
    end else if (en) begin
      v_en <= v_e & v_h;
    end
  end

  always_comb begin
    s_en_next = s_e;
    if (ev_top != '0 && ev_top != '1) begin
      s_en_next.energy = ev[EW-1] ? lj_pkg::OUT_MIN : lj_pkg::OUT_MAX;
      s_en_next.sat    = 1'b1;
    end else begin
      s_en_next.energy = ev[OW-1:0];
      s_en_next.sat    = s_e.sat | s_h.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_en <= h_mag;
      s_en <= s_en_next;
    end
  end

  // w = h / r2
  lj_div u_div_w (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_en),
    .num(h_en), .den(s_en.r2), .side_in(s_en),
    .out_valid(v_w), .quot(w_mag), .side_out(s_w)
  );

  // force magnitude per axis
  for (genvar m = 0; m < NA; m++) begin : g_force
    lj_mul u_mul_f (
      .clk(clk), .rst(rst), .en(en), .in_valid(v_w),
      .a(MW'(w_mag)), .b(MW'(s_w.mag[m])), .shift(lj_pkg::SH_Q32),
      .cap(lj_pkg::CAP_OUTER), .side_in(s_w),
      .out_valid(v_f[m]), .result(f_mag[m]), .side_out(s_f[m])
    );
  end

  assign v_last = &v_f;

  // signs, output saturation, zeroing of misses
  always_comb begin
    logic neg;
    sat_f    = 1'b0;
    fin_data = '0;
    for (int m = 0; m < NA; m++) begin
      neg   = s_f[0].fneg != s_f[0].dneg[m];
      sat_f = sat_f | s_f[m].sat;
      if (neg) begin
        if (f_mag[m] > QW'(lj_pkg::OUT_MIN)) begin
          fin_data[m*OW +: OW] = lj_pkg::OUT_MIN;
          sat_f = 1'b1;
        end else begin
          fin_data[m*OW +: OW] = OW'(-f_mag[m]);
        end
      end else begin
        if (f_mag[m] > QW'(lj_pkg::OUT_MAX)) begin
          fin_data[m*OW +: OW] = lj_pkg::OUT_MAX;
          sat_f = 1'b1;
        end else begin
          fin_data[m*OW +: OW] = f_mag[m][OW-1:0];
        end
      end
    end
    fin_data[NA*OW +: OW] = s_f[0].energy;
    fin_user = {sat_f, 1'b1};
    if (!s_f[0].hit) begin
      fin_data = '0;
      fin_user = '0;
    end
  end

  // output register with one skid entry behind it
  assign incoming = en && v_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (m_axis_tvalid && !m_axis_tready) begin
      if (incoming) begin
        skid_valid <= 1'b1;
      end
    end else begin
      m_axis_tvalid <= skid_valid || incoming;
      skid_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tvalid && !m_axis_tready) begin
      if (incoming) begin
        skid_data <= fin_data;
        skid_user <= fin_user;
      end
    end else if (skid_valid) begin
      m_axis_tdata <= skid_data;
      m_axis_tuser <= skid_user;
    end else begin
      m_axis_tdata <= fin_data;
      m_axis_tuser <= fin_user;
    end
  end

endmodule

### rtl/lj_checker.sv
// port-level checks of the pair force block and their binding
`include "assert_macros.svh"

module lj_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [lj_pkg::DATA_W-1:0]  m_axis_tdata,
  input logic [lj_pkg::USER_W-1:0]  m_axis_tuser
);

  // a held result does not change
  `AST_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // a pair outside the cutoff carries only zeros
  `AST_IMPL(a_miss_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0 && !m_axis_tuser[1])

  // input stalls only while a result is waiting at the output
  `AST_IMPL(a_stall_cause, clk, rst, !s_axis_tready, m_axis_tvalid)

  // reset empties the output and opens the input
  `AST_AFTER_RST(a_reset_state, clk, rst, !m_axis_tvalid && s_axis_tready)

endmodule

bind lennard_jones_pair_force lj_checker u_lj_checker (.*);

### test/tb_lennard_jones_pair_force.sv
// testbench for the lennard-jones pair force pipeline: random pair stream against a local predictor
`timescale 1ns / 100ps

module tb_lennard_jones_pair_force;
  import lj_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] force_x;
    logic [OUT_W-1:0] force_y;
    logic [OUT_W-1:0] force_z;
    logic [OUT_W-1:0] pair_energy;
    logic             in_range;
    logic             saturated;
  } pair_result_t;

  localparam logic [63:0] Q62_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] Q50_CAP = 64'h0004_0000_0000_0000;
  localparam logic [63:0] UNIT    = 64'h0000_0001_0000_0000;
  localparam longint      FAR_D   = 64'sd16777216;
  localparam longint      POS_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint      NEG_MIN = -64'sh8000_0000_0000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;
  logic [USER_W-1:0]   m_axis_tuser;
  logic                cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  // register mirror used by the predictor
  logic [63:0] well_depth, sigma_sixth, cutoff_sq;
  longint      energy_shift;
  longint      box_len [3];
  bit          periodic;
  bit          pred_sat;

  logic [IN_W-1:0] pending_pairs [$];
  pair_result_t    expected_results [$];
  int              error_count = 0;
  int              result_count = 0;

  lennard_jones_pair_force uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // floor(a*b / 2^sh), clipped
  function automatic logic [63:0] scaled_mul(logic [63:0] a, logic [63:0] b, int sh,
                                             logic [63:0] cap);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    if (p[127:64] != 0 || p[63:0] > cap) begin
      pred_sat = 1'b1;
      return cap;
    end
    return p[63:0];
  endfunction

  // floor(num * 2^sh / den), clipped
  function automatic logic [63:0] scaled_div(logic [63:0] num, int sh, logic [63:0] den,
                                             logic [63:0] cap);
    logic [127:0] q;
    q = ({64'b0, num} << sh) / {64'b0, den};
    if (q[127:64] != 0 || q[63:0] > cap) begin
      pred_sat = 1'b1;
      return cap;
    end
    return q[63:0];
  endfunction

  function automatic logic [OUT_W-1:0] signed_force(logic [63:0] mag, bit neg);
    longint v;
    if (neg) begin
      if (mag > 64'h0000_8000_0000_0000) begin
        pred_sat = 1'b1;
        v = NEG_MIN;
      end else v = -longint'(mag);
    end else begin
      if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
        pred_sat = 1'b1;
        v = POS_MAX;
      end else v = longint'(mag);
    end
    return v[OUT_W-1:0];
  endfunction

  // force and shifted energy of one atom pair
  function automatic pair_result_t pair_interaction(logic [IN_W-1:0] pair);
    pair_result_t res;
    longint       disp [3];
    logic [63:0]  mag [3];
    logic [63:0]  r2, b2, t, p, e, g, h, w, two_b2, f;
    longint       x, len, ev, a, b;
    bit           far, neg;
    res = '{default: '0};
    pred_sat = 1'b0;
    far = 1'b0;
    r2 = 0;
    for (int m = 0; m < 3; m++) begin
      disp[m] = 0;
      mag[m] = 0;
    end
    for (int m = 0; m < DIMS; m++) begin
      a = $signed(pair[m*POS_W +: POS_W]);
      b = $signed(pair[(m+3)*POS_W +: POS_W]);
      x = a - b;
      len = box_len[m];
      // minimum image into (-L/2, L/2]
      if (periodic && len > 0) begin
        x = x % len;
        if (x < 0) x = x + len;
        if (2 * x > len) x = x - len;
      end
      disp[m] = x;
      mag[m] = (x < 0) ? -x : x;
      if (x >= FAR_D || x <= -FAR_D) far = 1'b1;
      else r2 = r2 + mag[m] * mag[m];
    end
    if (far || r2 == 0 || r2 >= (cutoff_sq << 16)) return res;

    b2 = scaled_div(sigma_sixth << 16, 32, r2, Q62_CAP);
    b2 = scaled_div(b2, 32, r2, Q62_CAP);
    b2 = scaled_div(b2, 32, r2, Q62_CAP);

    // energy
    neg = b2 < UNIT;
    t = neg ? UNIT - b2 : b2 - UNIT;
    p = scaled_mul(b2, t, 32, Q62_CAP);
    e = scaled_mul(well_depth, p, 30, Q50_CAP);
    ev = (neg ? -longint'(e) : longint'(e)) - energy_shift;
    if (ev > POS_MAX) begin
      pred_sat = 1'b1;
      ev = POS_MAX;
    end else if (ev < NEG_MIN) begin
      pred_sat = 1'b1;
      ev = NEG_MIN;
    end
    res.pair_energy = ev[OUT_W-1:0];

    // force scale then per axis
    two_b2 = 2 * b2;
    neg = two_b2 < UNIT;
    t = neg ? UNIT - two_b2 : two_b2 - UNIT;
    g = scaled_mul(b2, t, 32, Q62_CAP);
    h = scaled_mul(64'd24 * well_depth, g, 16, Q62_CAP);
    w = scaled_div(h, 32, r2, Q62_CAP);
    for (int m = 0; m < DIMS; m++) begin
      f = scaled_mul(w, mag[m], 32, Q50_CAP);
      case (m)
        0: res.force_x = signed_force(f, neg != (disp[m] < 0));
        1: res.force_y = signed_force(f, neg != (disp[m] < 0));
        default: res.force_z = signed_force(f, neg != (disp[m] < 0));
      endcase
    end
    res.in_range = 1'b1;
    res.saturated = pred_sat;
    return res;
  endfunction

  // sender: bursts and gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(pair_interaction(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          s_axis_tdata <= pending_pairs.pop_front();
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 60);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off to back up the pipeline
  int ready_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  pair_result_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.force_x     = m_axis_tdata[0*OUT_W +: OUT_W];
        got.force_y     = m_axis_tdata[1*OUT_W +: OUT_W];
        got.force_z     = m_axis_tdata[2*OUT_W +: OUT_W];
        got.pair_energy = m_axis_tdata[3*OUT_W +: OUT_W];
        got.in_range    = m_axis_tuser[0];
        got.saturated   = m_axis_tuser[1];
        result_count++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no pair pending");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.force_x !== want.force_x) begin
            $error("force_x expected %h got %h", want.force_x, got.force_x);
            error_count++;
          end
          if (got.force_y !== want.force_y) begin
            $error("force_y expected %h got %h", want.force_y, got.force_y);
            error_count++;
          end
          if (got.force_z !== want.force_z) begin
            $error("force_z expected %h got %h", want.force_z, got.force_z);
            error_count++;
          end
          if (got.pair_energy !== want.pair_energy) begin
            $error("pair_energy expected %h got %h", want.pair_energy, got.pair_energy);
            error_count++;
          end
          if (got.in_range !== want.in_range) begin
            $error("in_range expected %b got %b", want.in_range, got.in_range);
            error_count++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated expected %b got %b", want.saturated, got.saturated);
            error_count++;
          end
        end
        // early in the long first run, so the sender still has plenty queued
        if (result_count == 20 && !hold_done) begin
          hold_done = 1'b1;
          hold_left = 1500;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (ready_left > 0) ready_left--;
        else begin
          ready_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
          stall_left = $urandom_range(1, 6);
        end
      end
    end
  end

  task automatic set_reg(reg_index_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_WELL_DEPTH:   well_depth = value;
      REG_SIGMA_SIXTH:  sigma_sixth = value;
      REG_CUTOFF_SQ:    cutoff_sq = value;
      REG_ENERGY_SHIFT: energy_shift = $signed(value);
      REG_BOX_X:        box_len[0] = value[30:0];
      REG_BOX_Y:        box_len[1] = value[30:0];
      REG_BOX_Z:        box_len[2] = value[30:0];
      REG_PERIODIC:     periodic = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [IN_W-1:0] pack_pair(logic [31:0] fx, logic [31:0] fy,
                                                 logic [31:0] fz, logic [31:0] sx,
                                                 logic [31:0] sy, logic [31:0] sz);
    return {sz, sy, sx, fz, fy, fx};
  endfunction

  // random pair: mostly close neighbors, some image-shifted, some self pairs, some anywhere
  function automatic logic [IN_W-1:0] random_pair();
    logic [31:0] first [3];
    logic [31:0] second [3];
    int          kind;
    kind = $urandom_range(0, 9);
    for (int m = 0; m < 3; m++) begin
      first[m] = $urandom;
      if (kind == 0) second[m] = $urandom;
      else if (kind == 1) second[m] = first[m];
      else begin
        second[m] = first[m] - (32'($urandom_range(0, 524288)) - 32'd262144);
        if (kind >= 7 && box_len[m] > 0)
          second[m] = second[m] + 32'(box_len[m]) * 32'($urandom_range(0, 6) - 3);
      end
    end
    return pack_pair(first[0], first[1], first[2], second[0], second[1], second[2]);
  endfunction

  task automatic settle();
    wait (pending_pairs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) pending_pairs.push_back(random_pair());
    settle();
  endtask

  initial begin
    well_depth = 64'd65536;
    sigma_sixth = 64'd65536;
    cutoff_sq = 64'd589824;
    energy_shift = 0;
    for (int m = 0; m < 3; m++) box_len[m] = 655360;
    periodic = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // default registers: self pair, far axis, position extremes, close pairs
    pending_pairs.push_back(pack_pair(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0));
    pending_pairs.push_back(pack_pair(32'h0100_0000, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(0, 0, 32'h0001_0000, 0, 0, 32'hFF00_0000));
    pending_pairs.push_back(pack_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_pairs.push_back(pack_pair(32'h8000_0000, 32'h7FFF_FFFF, 0,
                                      32'h7FFF_FFFF, 32'h8000_0000, 0));
    pending_pairs.push_back(pack_pair(32'h0001_0000, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(0, 32'hFFFF_8000, 32'h0000_8000, 0, 0, 0));
    pending_pairs.push_back(pack_pair(32'h0000_0001, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(32'h0002_FFFF, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(32'h0003_0000, 0, 0, 0, 0, 0));
    // longer than the pipeline holds, so the long hold-off fills it
    random_run(600);

    // sigma^6 = 0.5 puts 2*b2 at exactly one for r = 1
    set_reg(REG_SIGMA_SIXTH, 32'h0000_8000);
    pending_pairs.push_back(pack_pair(32'h0001_0000, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(0, 0, 0, 0, 32'h0001_0000, 0));
    random_run(150);

    // periodic wrap, small boxes, no wrap on z
    set_reg(REG_PERIODIC, 32'd1);
    set_reg(REG_BOX_X, 32'h0003_0000);
    set_reg(REG_BOX_Y, 32'h0004_8000);
    set_reg(REG_BOX_Z, 32'd0);
    set_reg(REG_ENERGY_SHIFT, 32'hFFFF_C000);
    pending_pairs.push_back(pack_pair(32'h0001_8000, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(0, 0, 0, 32'h0001_8000, 0, 0));
    pending_pairs.push_back(pack_pair(32'h0003_0000, 32'h0000_8000, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
    random_run(200);

    // registers at their top values, energy shift at its most negative
    set_reg(REG_WELL_DEPTH, 32'hFFFF_FFFF);
    set_reg(REG_SIGMA_SIXTH, 32'hFFFF_FFFF);
    set_reg(REG_CUTOFF_SQ, 32'hFFFF_FFFF);
    set_reg(REG_ENERGY_SHIFT, 32'h8000_0000);
    set_reg(REG_BOX_X, 32'h7FFF_FFFF);
    set_reg(REG_BOX_Y, 32'h7FFF_FFFF);
    set_reg(REG_BOX_Z, 32'h7FFF_FFFF);
    pending_pairs.push_back(pack_pair(32'h0000_0001, 0, 0, 0, 0, 0));
    pending_pairs.push_back(pack_pair(32'h00FF_FFFF, 0, 0, 0, 0, 0));
    random_run(200);

    // all registers but the energy shift at zero, shift at its most positive, then a wider cutoff
    set_reg(REG_WELL_DEPTH, 32'd0);
    set_reg(REG_SIGMA_SIXTH, 32'd0);
    set_reg(REG_CUTOFF_SQ, 32'd0);
    set_reg(REG_ENERGY_SHIFT, 32'h7FFF_FFFF);
    set_reg(REG_BOX_X, 32'd0);
    set_reg(REG_BOX_Y, 32'd0);
    set_reg(REG_BOX_Z, 32'd0);
    set_reg(REG_PERIODIC, 32'd0);
    random_run(60);
    set_reg(REG_CUTOFF_SQ, 32'h0010_0000);
    random_run(140);

    // mixed random settings
    for (int phase = 0; phase < 4; phase++) begin
      set_reg(REG_WELL_DEPTH, $urandom_range(0, 32'h0008_0000));
      set_reg(REG_SIGMA_SIXTH, $urandom_range(0, 32'h0010_0000));
      set_reg(REG_CUTOFF_SQ, $urandom_range(32'h0001_0000, 32'h0019_0000));
      set_reg(REG_ENERGY_SHIFT, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
      set_reg(REG_BOX_X, $urandom_range(32'h0000_8000, 32'h000A_0000));
      set_reg(REG_BOX_Y, $urandom_range(32'h0000_8000, 32'h000A_0000));
      set_reg(REG_BOX_Z, $urandom_range(32'h0000_8000, 32'h000A_0000));
      set_reg(REG_PERIODIC, $urandom_range(0, 1));
      random_run(100);
    end

    repeat (500) @(posedge clk);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lj_pkg.sv
rtl/lj_front.sv
rtl/lj_div.sv
rtl/lj_mul.sv
rtl/lennard_jones_pair_force.sv
rtl/lj_checker.sv
test/tb_lennard_jones_pair_force.sv
